>>> design/veh_pkg.sv
// shared types, constants and codes of the variable edge histogram
`default_nettype none
package veh_pkg;

  localparam int MAX_BINS      = 7;
  localparam int SAMPLE_BITS   = 32;

  localparam int NUM_EDGE_REGS = 6;
  localparam int NUM_INNER     = MAX_BINS - 1;
  localparam int BIN_W         = $clog2(MAX_BINS);
  localparam int FIELD_W       = 32;
  localparam int CMP_BITS      = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
  localparam bit TOP_REACHABLE = (SAMPLE_BITS <= FIELD_W);
  localparam int COUNT_W       = 32;
  localparam int SEL_W         = 3;
  localparam int EC_W          = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic signed [CMP_BITS-1:0] TOP_VALUE = {1'b0, {(CMP_BITS-1){1'b1}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_ONE   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } veh_op_e;

  // what the back end does with one queued request
  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_ZERO  = 2'd3
  } veh_kind_e;

  typedef struct packed {
    veh_op_e                    opcode;
    logic signed [FIELD_W-1:0]  sample_value;
    logic        [SEL_W-1:0]    bin_select;
  } veh_in_t;

  typedef struct packed {
    logic               hit;
    logic [SEL_W-1:0]   bin_index;
    logic [COUNT_W-1:0] bin_count;
  } veh_out_t;

  typedef struct packed {
    veh_kind_e          kind;
    logic [BIN_W-1:0]   bin;
  } veh_cmd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } veh_qstat_t;

endpackage
`default_nettype wire

>>> design/veh_front.sv
// front end: configuration registers, request acceptance and bin classification
`default_nettype none
module veh_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic                            busy_i,
  input  wire veh_pkg::veh_in_t                cmd_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [veh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [veh_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                                 push_o,
  output veh_pkg::veh_cmd_t                    push_cmd_o
);
  import veh_pkg::*;

  logic [EC_W-1:0]    edge_count_q;
  logic [FIELD_W-1:0] edge_q [NUM_EDGE_REGS];

  logic signed [CMP_BITS-1:0] v;
  logic [BIN_W-1:0]           n;
  logic [NUM_INNER-1:0]       lt;
  logic [MAX_BINS-1:0]        ub;
  logic [MAX_BINS-1:0]        lb;
  logic                       top_ok;
  logic                       found;
  logic [BIN_W-1:0]           bin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q <= '0;
      for (int j = 0; j < NUM_EDGE_REGS; j++) begin
        edge_q[j] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_EDGE_COUNT) begin
        edge_count_q <= cfg_wdata_i[EC_W-1:0];
      end
      for (int j = 0; j < NUM_EDGE_REGS; j++) begin
        if (cfg_idx_i == CFG_EDGE_ONE + CFG_IDX_W'(j)) begin
          edge_q[j] <= cfg_wdata_i[FIELD_W-1:0];
        end
      end
    end
  end

  assign v = $signed(cmd_i.sample_value[CMP_BITS-1:0]);

  // edge count above the bins available is clamped
  assign n = (edge_count_q > EC_W'(NUM_INNER)) ? BIN_W'(NUM_INNER)
                                                : BIN_W'(edge_count_q);

  // the top value itself sits on the exclusive top bound
  assign top_ok = TOP_REACHABLE ? (v != TOP_VALUE) : 1'b1;

  always_comb begin
    for (int j = 0; j < NUM_INNER; j++) begin
      lt[j] = v < $signed(edge_q[j][CMP_BITS-1:0]);
    end
  end

  assign ub = {top_ok, lt};
  assign lb = {~lt, 1'b1};

  // lowest bin in use whose bounds hold wins
  always_comb begin
    found = 1'b0;
    bin   = '0;
    for (int k = 0; k < MAX_BINS; k++) begin
      if (!found && (BIN_W'(k) <= n) && lb[k] &&
          ((BIN_W'(k) == n) ? top_ok : ub[k])) begin
        found = 1'b1;
        bin   = BIN_W'(k);
      end
    end
  end

  assign push_o = start_i && !busy_i;

  always_comb begin
    push_cmd_o.kind = KIND_ZERO;
    push_cmd_o.bin  = '0;
    case (cmd_i.opcode)
      OP_COUNT: begin
        if (found) begin
          push_cmd_o.kind = KIND_COUNT;
          push_cmd_o.bin  = bin;
        end
      end
      OP_READ: begin
        if (cmd_i.bin_select < SEL_W'(MAX_BINS)) begin
          push_cmd_o.kind = KIND_READ;
          push_cmd_o.bin  = cmd_i.bin_select[BIN_W-1:0];
        end
      end
      OP_CLEAR: begin
        push_cmd_o.kind = KIND_CLEAR;
      end
      default: begin
        push_cmd_o.kind = KIND_ZERO;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> design/veh_queue.sv
// short request queue between the front and back ends
`default_nettype none
module veh_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire veh_pkg::veh_cmd_t   push_cmd_i,
  input  wire logic                pop_i,
  output veh_pkg::veh_cmd_t        pop_cmd_o,
  output veh_pkg::veh_qstat_t      stat_o
);
  import veh_pkg::*;

  veh_cmd_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign stat_o.full     = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.nonempty = (cnt_q != '0);

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && stat_o.nonempty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign pop_cmd_o = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

>>> design/veh_back.sv
// back end: bin counters, saturating update, clear and registered result
`default_nettype none
module veh_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire veh_pkg::veh_cmd_t  cmd_i,
  output logic                    done_o,
  output veh_pkg::veh_out_t       result_o
);
  import veh_pkg::*;

  logic [COUNT_W-1:0] count_q [MAX_BINS];
  logic [COUNT_W-1:0] cur;
  logic [COUNT_W-1:0] nxt;
  logic               done_q;
  veh_out_t           res_q, res_d;

  assign cur = count_q[cmd_i.bin];
  // saturate at all ones
  assign nxt = (&cur) ? cur : cur + 1'b1;

  always_comb begin
    res_d = '0;
    case (cmd_i.kind)
      KIND_COUNT: begin
        res_d.hit       = 1'b1;
        res_d.bin_index = SEL_W'(cmd_i.bin);
        res_d.bin_count = nxt;
      end
      KIND_READ: begin
        res_d.bin_count = cur;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_BINS; k++) begin
        count_q[k] <= '0;
      end
    end else if (valid_i) begin
      if (cmd_i.kind == KIND_CLEAR) begin
        for (int k = 0; k < MAX_BINS; k++) begin
          count_q[k] <= '0;
        end
      end else if (cmd_i.kind == KIND_COUNT) begin
        count_q[cmd_i.bin] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

>>> design/variable_edge_histogram_top.sv
// histogram with programmable bin edges: top level
// an accepted request is written into the queue, and the back end then registers its result and its done strobe
// throughput: one request per cycle while busy_o is low; the back end retires one queued request each cycle
// busy_o rises only if the two-entry request queue fills; the receiver cannot stall
// reset: asynchronous active low, clears edge registers, edge count, all bin counts
// and the queue; no clearing pass is needed
`default_nettype none
module variable_edge_histogram_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire veh_pkg::veh_in_t                cmd_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [veh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [veh_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                                 done_o,
  output veh_pkg::veh_out_t                    result_o
);
  import veh_pkg::*;

  logic       push;
  veh_cmd_t   push_cmd;
  veh_cmd_t   pop_cmd;
  veh_qstat_t qstat;

  veh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  veh_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (qstat.nonempty),
    .pop_cmd_o  (pop_cmd),
    .stat_o     (qstat)
  );

  veh_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (qstat.nonempty),
    .cmd_i    (pop_cmd),
    .done_o   (done_o),
    .result_o (result_o)
  );

  assign busy_o = qstat.full;

  a_done_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(qstat.nonempty))
    else $error("result strobe without a queued request");

  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> qstat.nonempty)
    else $error("accepted request did not reach the queue");

  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.hit) |-> (result_o.bin_count != '0))
    else $error("hit reported with a zero count");

  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.hit) |-> (result_o.bin_index == '0))
    else $error("bin index set without a hit");

endmodule
`default_nettype wire
